// ===== rtl/pci_pkg.sv =====
// Shared types, constants and helpers of the particle collision integrator.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package pci_pkg;

  // Field types of the input and result beats.
  typedef logic signed [31:0] q16_t;
  typedef logic signed [21:0] grav_t;
  typedef logic        [16:0] damp_t;
  typedef logic        [15:0] dt_t;
  typedef logic signed [15:0] norm_t;
  typedef logic        [30:0] pen_t;

  typedef enum logic [1:0] {
    OP_RESTART  = 2'd0,
    OP_TICK     = 2'd1,
    OP_BOUNDARY = 2'd2,
    OP_PARTICLE = 2'd3
  } op_t;

  // Configuration register indexes (byte address 4*i).
  localparam int CfgAddrW = 4;
  localparam logic [1:0] REG_GRAVITY = 2'd0;
  localparam logic [1:0] REG_DAMPING = 2'd1;
  localparam logic [1:0] REG_START_X = 2'd2;
  localparam logic [1:0] REG_START_Y = 2'd3;

  // Shared multiplier operand and product widths.
  localparam int MulAW = 36;
  localparam int MulBW = 24;
  localparam int ProdW = MulAW + MulBW;

  localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

  typedef struct packed {
    grav_t gravity;
    damp_t damping;
    q16_t  start_x;
    q16_t  start_y;
  } cfg_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_TICK1,
    MUL_TICK2,
    MUL_PEN,
    MUL_DOT_V,
    MUL_DOT_R,
    MUL_REFL,
    MUL_DAMP,
    MUL_J,
    MUL_IMP
  } mul_sel_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_RESTART,
    WB_TICK1,
    WB_TICK2,
    WB_PEN15,
    WB_PEN16,
    WB_SUM,
    WB_REFL,
    WB_DAMP,
    WB_JNEG,
    WB_IMP
  } wb_sel_t;

  typedef struct packed {
    logic     load_in;
    mul_sel_t mul_sel;
    wb_sel_t  wb_sel;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic sum_neg;
    logic sum_le_zero;
  } stat_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic q16_t sat32(input logic signed [63:0] v);
    q16_t r;
    if (v > Q_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < Q_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pci_if.sv =====
// Valid/ready channel interfaces for input beats and result beats.
// Depends on pci_pkg for the field types.
`default_nettype none

interface pci_in_if;
  logic            valid;
  logic            ready;
  pci_pkg::op_t    operation;
  pci_pkg::dt_t    step_time;
  pci_pkg::norm_t  normal_x;
  pci_pkg::norm_t  normal_y;
  pci_pkg::pen_t   penetration;
  pci_pkg::q16_t   other_vel_x;
  pci_pkg::q16_t   other_vel_y;
  pci_pkg::damp_t  other_damping;

  modport source(output valid, operation, step_time, normal_x, normal_y, penetration,
                 other_vel_x, other_vel_y, other_damping, input ready);
  modport sink(input valid, operation, step_time, normal_x, normal_y, penetration,
               other_vel_x, other_vel_y, other_damping, output ready);
endinterface

interface pci_out_if;
  logic          valid;
  logic          ready;
  pci_pkg::q16_t new_pos_x;
  pci_pkg::q16_t new_pos_y;
  pci_pkg::q16_t new_vel_x;
  pci_pkg::q16_t new_vel_y;
  pci_pkg::q16_t partner_delta_x;
  pci_pkg::q16_t partner_delta_y;

  modport source(output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                 partner_delta_x, partner_delta_y, input ready);
  modport sink(input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
               partner_delta_x, partner_delta_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/particle_collision_integrator.sv =====
// Top level of the particle collision integrator: configuration registers,
// controller and datapath. Depends on pci_pkg, pci_if, pci_cfg_regs,
// pci_ctrl and pci_datapath.
//
//   Channel   Kind             Direction  Carries
//   item      valid/ready      in         operation and contact/tick fields
//   result    valid/ready      out        new position, velocity, partner delta
//   apb       psel/penable     in/out     gravity, damping, start_x, start_y
//
// Sequencing: one item at a time, with the input beat taken in the idle cycle
// and the result register loaded in a final done cycle. Contacts that move
// apart end after the dot product; a reflecting boundary contact and a particle
// contact that applies an impulse run a chain of dependent products through
// the two shared multipliers, each product registered before its shift, add
// and saturate writeback.
// Stalls: a new beat is accepted while the previous result still waits; the
// sequence then holds in its done cycle until the result register is free.
// Reset (rst, synchronous) clears position and velocity to zero and returns
// the registers to gravity 642908 and damping 52429.
`default_nettype none

module particle_collision_integrator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  pci_in_if.sink                             item,
  pci_out_if.source                          result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pci_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  import pci_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  // Register file; writes are expected only while the block is idle.
  pci_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller decodes the operation on the accept cycle and steps the
  // datapath through multiply and writeback cycles.
  pci_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .operation    (item.operation),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd),
    .stat         (stat)
  );

  // The datapath holds the particle state and drives the result payload.
  pci_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg             (cfg),
    .step_time       (item.step_time),
    .normal_x        (item.normal_x),
    .normal_y        (item.normal_y),
    .penetration     (item.penetration),
    .other_vel_x     (item.other_vel_x),
    .other_vel_y     (item.other_vel_y),
    .other_damping   (item.other_damping),
    .new_pos_x       (result.new_pos_x),
    .new_pos_y       (result.new_pos_y),
    .new_vel_x       (result.new_vel_x),
    .new_vel_y       (result.new_vel_y),
    .partner_delta_x (result.partner_delta_x),
    .partner_delta_y (result.partner_delta_y)
  );

endmodule

`default_nettype wire

// ===== rtl/pci_cfg_regs.sv =====
// APB-style configuration registers: gravity, damping and restart position.
// Depends on pci_pkg.
`default_nettype none

module pci_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pci_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output pci_pkg::cfg_t                      cfg
);
  import pci_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CfgAddrW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gravity <= 22'sd642908;
      cfg.damping <= 17'd52429;
      cfg.start_x <= '0;
      cfg.start_y <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GRAVITY: cfg.gravity <= pwdata[21:0];
        REG_DAMPING: cfg.damping <= pwdata[16:0];
        REG_START_X: cfg.start_x <= pwdata;
        REG_START_Y: cfg.start_y <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRAVITY: prdata = 32'(cfg.gravity);
      REG_DAMPING: prdata = 32'(cfg.damping);
      REG_START_X: prdata = cfg.start_x;
      REG_START_Y: prdata = cfg.start_y;
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/pci_datapath.sv =====
// Datapath: particle state, two shared registered multipliers and the
// shift/add/saturate writeback logic. Depends on pci_pkg.
`default_nettype none

module pci_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire pci_pkg::cmd_t  cmd,
  output pci_pkg::stat_t      stat,
  input  wire pci_pkg::cfg_t  cfg,
  input  wire pci_pkg::dt_t   step_time,
  input  wire pci_pkg::norm_t normal_x,
  input  wire pci_pkg::norm_t normal_y,
  input  wire pci_pkg::pen_t  penetration,
  input  wire pci_pkg::q16_t  other_vel_x,
  input  wire pci_pkg::q16_t  other_vel_y,
  input  wire pci_pkg::damp_t other_damping,
  output pci_pkg::q16_t       new_pos_x,
  output pci_pkg::q16_t       new_pos_y,
  output pci_pkg::q16_t       new_vel_x,
  output pci_pkg::q16_t       new_vel_y,
  output pci_pkg::q16_t       partner_delta_x,
  output pci_pkg::q16_t       partner_delta_y
);
  import pci_pkg::*;

  // Held input fields.
  dt_t                dt_r;
  logic        [22:0] dt100_r;
  norm_t              nx_r;
  norm_t              ny_r;
  pen_t               pen_r;
  q16_t               ovx_r;
  q16_t               ovy_r;
  damp_t              odmp_r;

  // Particle state and per-item scratch.
  q16_t               pos_x;
  q16_t               pos_y;
  q16_t               vel_x;
  q16_t               vel_y;
  q16_t               dx_r;
  q16_t               dy_r;
  logic signed [32:0] rel_x;
  logic signed [32:0] rel_y;
  logic        [17:0] k_r;
  logic signed [MulAW-1:0] sum_r;
  logic signed [MulAW-1:0] j_r;

  // Multiplier operands and registered products.
  logic signed [MulAW-1:0] m0_a;
  logic signed [MulBW-1:0] m0_b;
  logic signed [MulAW-1:0] m1_a;
  logic signed [MulBW-1:0] m1_b;
  logic signed [ProdW-1:0] prod0;
  logic signed [ProdW-1:0] prod1;

  logic signed [63:0] p0_sh15;
  logic signed [63:0] p1_sh15;
  logic signed [63:0] p0_sh16;
  logic signed [63:0] p1_sh16;
  logic signed [63:0] prod_sum;
  logic signed [63:0] prod0_neg;
  damp_t              e_min;

  assign e_min = (cfg.damping < odmp_r) ? cfg.damping : odmp_r;

  always_comb begin
    m0_a = '0;
    m0_b = '0;
    m1_a = '0;
    m1_b = '0;
    case (cmd.mul_sel)
      MUL_TICK1: begin
        m0_a = MulAW'($signed({1'b0, dt100_r}));
        m0_b = MulBW'(cfg.gravity);
        m1_a = MulAW'(vel_x);
        m1_b = MulBW'($signed({1'b0, dt_r}));
      end
      MUL_TICK2: begin
        m0_a = MulAW'(vel_y);
        m0_b = MulBW'($signed({1'b0, dt_r}));
      end
      MUL_PEN: begin
        m0_a = MulAW'($signed({1'b0, pen_r}));
        m0_b = MulBW'(nx_r);
        m1_a = MulAW'($signed({1'b0, pen_r}));
        m1_b = MulBW'(ny_r);
      end
      MUL_DOT_V: begin
        m0_a = MulAW'(vel_x);
        m0_b = MulBW'(nx_r);
        m1_a = MulAW'(vel_y);
        m1_b = MulBW'(ny_r);
      end
      MUL_DOT_R: begin
        m0_a = MulAW'(rel_x);
        m0_b = MulBW'(nx_r);
        m1_a = MulAW'(rel_y);
        m1_b = MulBW'(ny_r);
      end
      MUL_REFL: begin
        // Twice the dot product; its magnitude stays well inside the operand.
        m0_a = {sum_r[MulAW-2:0], 1'b0};
        m0_b = MulBW'(nx_r);
        m1_a = {sum_r[MulAW-2:0], 1'b0};
        m1_b = MulBW'(ny_r);
      end
      MUL_DAMP: begin
        m0_a = MulAW'(vel_x);
        m0_b = MulBW'($signed({1'b0, cfg.damping}));
        m1_a = MulAW'(vel_y);
        m1_b = MulBW'($signed({1'b0, cfg.damping}));
      end
      MUL_J: begin
        m0_a = sum_r;
        m0_b = MulBW'($signed({1'b0, k_r}));
      end
      MUL_IMP: begin
        m0_a = j_r;
        m0_b = MulBW'(nx_r);
        m1_a = j_r;
        m1_b = MulBW'(ny_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod0 <= m0_a * m0_b;
    prod1 <= m1_a * m1_b;
  end

  always_comb begin
    p0_sh15   = 64'(prod0 >>> 15);
    p1_sh15   = 64'(prod1 >>> 15);
    p0_sh16   = 64'(prod0 >>> 16);
    p1_sh16   = 64'(prod1 >>> 16);
    prod_sum  = 64'(prod0) + 64'(prod1);
    prod0_neg = -64'(prod0);
  end

  // Approach tests on the dot product before it is registered.
  assign stat.sum_neg     = prod_sum[63];
  assign stat.sum_le_zero = prod_sum < 64'sd32768;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dt_r    <= step_time;
      dt100_r <= {1'b0, step_time, 6'b0} + {2'b0, step_time, 5'b0} + {5'b0, step_time, 2'b0};
      nx_r    <= normal_x;
      ny_r    <= normal_y;
      pen_r   <= penetration;
      ovx_r   <= other_vel_x;
      ovy_r   <= other_vel_y;
      odmp_r  <= other_damping;
    end
    if (cmd.mul_sel == MUL_PEN) begin
      rel_x <= 33'(vel_x) - 33'(ovx_r);
      rel_y <= 33'(vel_y) - 33'(ovy_r);
      k_r   <= 18'(e_min) + 18'h10000;
    end
    case (cmd.wb_sel)
      WB_SUM:  sum_r <= MulAW'(prod_sum >>> 15);
      WB_JNEG: j_r   <= MulAW'(prod0_neg >>> 17);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      vel_x <= '0;
      vel_y <= '0;
      dx_r  <= '0;
      dy_r  <= '0;
    end else begin
      if (cmd.load_in) begin
        dx_r <= '0;
        dy_r <= '0;
      end
      case (cmd.wb_sel)
        WB_RESTART: begin
          pos_x <= cfg.start_x;
          pos_y <= cfg.start_y;
          vel_x <= '0;
          vel_y <= '0;
        end
        WB_TICK1: begin
          vel_y <= sat32(64'(vel_y) + p0_sh16);
          pos_x <= sat32(64'(pos_x) + p1_sh16);
        end
        WB_TICK2: pos_y <= sat32(64'(pos_y) + p0_sh16);
        WB_PEN15: begin
          pos_x <= sat32(64'(pos_x) + p0_sh15);
          pos_y <= sat32(64'(pos_y) + p1_sh15);
        end
        WB_PEN16: begin
          pos_x <= sat32(64'(pos_x) + p0_sh16);
          pos_y <= sat32(64'(pos_y) + p1_sh16);
        end
        WB_REFL: begin
          vel_x <= sat32(64'(vel_x) - p0_sh15);
          vel_y <= sat32(64'(vel_y) - p1_sh15);
        end
        WB_DAMP: begin
          vel_x <= sat32(p0_sh16);
          vel_y <= sat32(p1_sh16);
        end
        WB_IMP: begin
          vel_x <= sat32(64'(vel_x) + p0_sh15);
          vel_y <= sat32(64'(vel_y) + p1_sh15);
          dx_r  <= sat32(-p0_sh15);
          dy_r  <= sat32(-p1_sh15);
        end
        default: ;
      endcase
    end
  end

  // Result register, loaded when the controller hands a beat out.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      new_pos_x       <= pos_x;
      new_pos_y       <= pos_y;
      new_vel_x       <= vel_x;
      new_vel_y       <= vel_y;
      partner_delta_x <= dx_r;
      partner_delta_y <= dy_r;
    end
  end

  // The impulse magnitude is only formed for approaching pairs.
  a_j_nonneg: assert property (@(posedge clk) disable iff (rst)
    (cmd.wb_sel == WB_JNEG) |=> !j_r[MulAW-1])
    else $error("impulse magnitude went negative");

  a_delta_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> (dx_r == '0 && dy_r == '0))
    else $error("partner delta not cleared for a new item");

endmodule

`default_nettype wire

// ===== rtl/pci_ctrl.sv =====
// Controller state machine: sequences the multiplier and writeback commands
// for each operation and owns both handshakes. Depends on pci_pkg.
`default_nettype none

module pci_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire pci_pkg::op_t   operation,
  output logic                result_valid,
  input  wire logic           result_ready,
  output pci_pkg::cmd_t       cmd,
  input  wire pci_pkg::stat_t stat
);
  import pci_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE      = 21'h000001,
    S_RST       = 21'h000002,
    S_T_MUL1    = 21'h000004,
    S_T_WB1     = 21'h000008,
    S_T_MUL2    = 21'h000010,
    S_T_WB2     = 21'h000020,
    S_B_PEN     = 21'h000040,
    S_B_DOT     = 21'h000080,
    S_B_SUM     = 21'h000100,
    S_B_REFL    = 21'h000200,
    S_B_REFL_WB = 21'h000400,
    S_B_DAMP    = 21'h000800,
    S_B_DAMP_WB = 21'h001000,
    S_P_PEN     = 21'h002000,
    S_P_DOT     = 21'h004000,
    S_P_SUM     = 21'h008000,
    S_P_JMUL    = 21'h010000,
    S_P_JNEG    = 21'h020000,
    S_P_IMP     = 21'h040000,
    S_P_IMP_WB  = 21'h080000,
    S_DONE      = 21'h100000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next   = state;
    item_ready   = 1'b0;
    cmd.load_in  = 1'b0;
    cmd.mul_sel  = MUL_NONE;
    cmd.wb_sel   = WB_NONE;
    cmd.load_out = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load_in = 1'b1;
          case (operation)
            OP_RESTART:  state_next = S_RST;
            OP_TICK:     state_next = S_T_MUL1;
            OP_BOUNDARY: state_next = S_B_PEN;
            OP_PARTICLE: state_next = S_P_PEN;
            default:     state_next = S_RST;
          endcase
        end
      end
      S_RST: begin
        cmd.wb_sel = WB_RESTART;
        state_next = S_DONE;
      end
      S_T_MUL1: begin
        cmd.mul_sel = MUL_TICK1;
        state_next  = S_T_WB1;
      end
      S_T_WB1: begin
        cmd.wb_sel = WB_TICK1;
        state_next = S_T_MUL2;
      end
      S_T_MUL2: begin
        cmd.mul_sel = MUL_TICK2;
        state_next  = S_T_WB2;
      end
      S_T_WB2: begin
        cmd.wb_sel = WB_TICK2;
        state_next = S_DONE;
      end
      S_B_PEN: begin
        cmd.mul_sel = MUL_PEN;
        state_next  = S_B_DOT;
      end
      S_B_DOT: begin
        cmd.wb_sel  = WB_PEN15;
        cmd.mul_sel = MUL_DOT_V;
        state_next  = S_B_SUM;
      end
      S_B_SUM: begin
        cmd.wb_sel = WB_SUM;
        state_next = stat.sum_neg ? S_B_REFL : S_DONE;
      end
      S_B_REFL: begin
        cmd.mul_sel = MUL_REFL;
        state_next  = S_B_REFL_WB;
      end
      S_B_REFL_WB: begin
        cmd.wb_sel = WB_REFL;
        state_next = S_B_DAMP;
      end
      S_B_DAMP: begin
        cmd.mul_sel = MUL_DAMP;
        state_next  = S_B_DAMP_WB;
      end
      S_B_DAMP_WB: begin
        cmd.wb_sel = WB_DAMP;
        state_next = S_DONE;
      end
      S_P_PEN: begin
        cmd.mul_sel = MUL_PEN;
        state_next  = S_P_DOT;
      end
      S_P_DOT: begin
        cmd.wb_sel  = WB_PEN16;
        cmd.mul_sel = MUL_DOT_R;
        state_next  = S_P_SUM;
      end
      S_P_SUM: begin
        cmd.wb_sel = WB_SUM;
        state_next = stat.sum_le_zero ? S_P_JMUL : S_DONE;
      end
      S_P_JMUL: begin
        cmd.mul_sel = MUL_J;
        state_next  = S_P_JNEG;
      end
      S_P_JNEG: begin
        cmd.wb_sel = WB_JNEG;
        state_next = S_P_IMP;
      end
      S_P_IMP: begin
        cmd.mul_sel = MUL_IMP;
        state_next  = S_P_IMP_WB;
      end
      S_P_IMP_WB: begin
        cmd.wb_sel = WB_IMP;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!result_valid || result_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cmd.mul_sel == MUL_NONE && cmd.wb_sel == WB_NONE))
    else $error("datapath command issued while idle");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> result_valid)
    else $error("result register loaded but not presented");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> (state != S_IDLE))
    else $error("accepted item did not start a sequence");

endmodule

`default_nettype wire

// ===== tb/particle_collision_integrator_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the particle collision integrator: it follows the register
// writes, predicts every result beat from the item beats and compares them.
// Depends on pci_pkg and the pci_in_if / pci_out_if interfaces.

module particle_collision_integrator_checker
  import pci_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  pci_in_if                   item,
  pci_out_if                  result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output int                  pending,
  output int                  mismatches
);

  typedef struct packed {
    q16_t pos_x;
    q16_t pos_y;
    q16_t vel_x;
    q16_t vel_y;
    q16_t push_x;
    q16_t push_y;
  } particle_result_t;

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;

  grav_t  gravity_r;
  damp_t  damping_r;
  q16_t   home_x;
  q16_t   home_y;
  longint px, py, vx, vy;
  int     errors = 0;

  particle_result_t expected_results[$];

  function automatic longint clamp_q16(input longint v);
    longint r;
    r = v;
    if (v > QMax) begin
      r = QMax;
    end else if (v < QMin) begin
      r = QMin;
    end
    return r;
  endfunction

  // Applies one item to the mirrored particle and returns the result it should give.
  // Products are exact in 64 bits; >>> on a signed value rounds toward minus infinity.
  function automatic particle_result_t advance_particle(
      input op_t op, input dt_t dt_f, input norm_t nx_f, input norm_t ny_f,
      input pen_t pen_f, input q16_t ovx_f, input q16_t ovy_f, input damp_t odmp_f);
    particle_result_t r;
    longint dt, nx, ny, pen, ovx, ovy, odmp, grav, damp;
    longint dot, rvx, rvy, closing, e, j, ix, iy, dx, dy;
    dt   = dt_f;
    nx   = nx_f;
    ny   = ny_f;
    pen  = pen_f;
    ovx  = ovx_f;
    ovy  = ovy_f;
    odmp = odmp_f;
    grav = gravity_r;
    damp = damping_r;
    dx   = 0;
    dy   = 0;
    case (op)
      OP_RESTART: begin
        px = home_x;
        py = home_y;
        vx = 0;
        vy = 0;
      end
      OP_TICK: begin
        vy = clamp_q16(vy + ((grav * dt * 100) >>> 16));
        px = clamp_q16(px + ((vx * dt) >>> 16));
        py = clamp_q16(py + ((vy * dt) >>> 16));
      end
      OP_BOUNDARY: begin
        px  = clamp_q16(px + ((nx * pen) >>> 15));
        py  = clamp_q16(py + ((ny * pen) >>> 15));
        dot = (vx * nx + vy * ny) >>> 15;
        if (dot < 0) begin
          vx = clamp_q16(vx - ((2 * dot * nx) >>> 15));
          vy = clamp_q16(vy - ((2 * dot * ny) >>> 15));
          vx = clamp_q16((vx * damp) >>> 16);
          vy = clamp_q16((vy * damp) >>> 16);
        end
      end
      default: begin
        px      = clamp_q16(px + ((nx * pen) >>> 16));
        py      = clamp_q16(py + ((ny * pen) >>> 16));
        rvx     = vx - ovx;
        rvy     = vy - ovy;
        closing = (rvx * nx + rvy * ny) >>> 15;
        if (closing <= 0) begin
          e  = (damp < odmp) ? damp : odmp;
          j  = (-(65536 + e) * closing) >>> 17;
          ix = (j * nx) >>> 15;
          iy = (j * ny) >>> 15;
          vx = clamp_q16(vx + ix);
          vy = clamp_q16(vy + iy);
          dx = clamp_q16(-ix);
          dy = clamp_q16(-iy);
        end
      end
    endcase
    r.pos_x  = q16_t'(px);
    r.pos_y  = q16_t'(py);
    r.vel_x  = q16_t'(vx);
    r.vel_y  = q16_t'(vy);
    r.push_x = q16_t'(dx);
    r.push_y = q16_t'(dy);
    return r;
  endfunction

  task automatic compare_field(input string name, input q16_t want, input q16_t got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    particle_result_t want;
    if (rst) begin
      gravity_r = 22'sd642908;
      damping_r = 17'd52429;
      home_x    = '0;
      home_y    = '0;
      px        = 0;
      py        = 0;
      vx        = 0;
      vy        = 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_GRAVITY: gravity_r = grav_t'(pwdata[21:0]);
          REG_DAMPING: damping_r = pwdata[16:0];
          REG_START_X: home_x = pwdata;
          REG_START_Y: home_y = pwdata;
          default: ;
        endcase
      end
      if (item.valid && item.ready) begin
        expected_results.push_back(advance_particle(item.operation, item.step_time,
            item.normal_x, item.normal_y, item.penetration, item.other_vel_x,
            item.other_vel_y, item.other_damping));
      end
      if (result.valid && result.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat arrived with no item beat outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          compare_field("new_pos_x", want.pos_x, result.new_pos_x);
          compare_field("new_pos_y", want.pos_y, result.new_pos_y);
          compare_field("new_vel_x", want.vel_x, result.new_vel_x);
          compare_field("new_vel_y", want.vel_y, result.new_vel_y);
          compare_field("partner_delta_x", want.push_x, result.partner_delta_x);
          compare_field("partner_delta_y", want.push_y, result.partner_delta_y);
        end
      end
    end
    pending    <= expected_results.size();
    mismatches <= errors;
  end

endmodule

// ===== tb/particle_collision_integrator_tb.sv =====
`timescale 1ns / 100ps
// Top of the particle collision integrator testbench: clock, reset, register
// writes and item stimulus, with the scoreboard instantiated beside the block.
// Depends on pci_pkg, pci_if, the block's RTL and the scoreboard module.

module particle_collision_integrator_tb;
  import pci_pkg::*;

  // A quiet stretch far longer than the slowest item, a sender gap, a receiver
  // stall and a register phase together means the block has hung.
  localparam int StuckLimit = 2000;

  localparam norm_t NormMin = 16'sh8000;
  localparam norm_t NormMax = 16'sh7fff;
  localparam q16_t  QLow    = 32'sh80000000;
  localparam q16_t  QHigh   = 32'sh7fffffff;
  localparam pen_t  PenMax  = 31'h7fffffff;

  logic                clk     = 1'b0;
  logic                rst     = 1'b1;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [CfgAddrW-1:0] paddr   = '0;
  logic [31:0]         pwdata  = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Receiver side: ready is held low in random bursts while idling is on.
  logic sink_ready = 1'b0;
  logic idle_en    = 1'b1;
  int   stall_left = 0;
  int   stuck      = 0;
  int   pending;
  int   mismatches;

  pci_in_if  item_ch ();
  pci_out_if result_ch ();

  assign result_ch.ready = sink_ready;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  particle_collision_integrator DUT (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  particle_collision_integrator_checker scoreboard (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pending    (pending),
    .mismatches (mismatches)
  );

  // A stall drives ready low and keeps it low while a randomly drawn remaining
  // count runs down. Once idling is switched off the current burst runs out
  // and ready then stays high.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 12);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Watchdog: any beat on either channel counts as progress.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck >= StuckLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Setup cycle, then access cycle; the register takes the data at the edge
  // where the access phase meets pready. The bus is released for one cycle
  // afterwards so that back-to-back writes never drive psel twice in a step.
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Gravity and damping are narrower than the bus. Half the time the unused
  // upper bits carry random junk, which the block must ignore.
  task automatic configure(input grav_t g, input damp_t d, input q16_t sx, input q16_t sy);
    logic [9:0]  g_top;
    logic [14:0] d_top;
    g_top = $urandom_range(0, 1) ? 10'($urandom) : 10'd0;
    d_top = $urandom_range(0, 1) ? 15'($urandom) : 15'd0;
    apb_write(REG_GRAVITY, {g_top, g});
    apb_write(REG_DAMPING, {d_top, d});
    apb_write(REG_START_X, sx);
    apb_write(REG_START_Y, sy);
  endtask

  // Offers one item beat and returns at the edge where it is taken. Valid
  // is left high, so the next call can present its beat in the same step
  // without a gap.
  task automatic send_beat(input op_t op, input dt_t dt, input norm_t nx, input norm_t ny,
                           input pen_t pen, input q16_t ovx, input q16_t ovy,
                           input damp_t odmp);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.operation     <= op;
    item_ch.step_time     <= dt;
    item_ch.normal_x      <= nx;
    item_ch.normal_y      <= ny;
    item_ch.penetration   <= pen;
    item_ch.other_vel_x   <= ovx;
    item_ch.other_vel_y   <= ovy;
    item_ch.other_damping <= odmp;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // Stops offering beats until every predicted result has arrived. The first
  // edge lets the scoreboard count the beat that was just taken.
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic norm_t pick_normal();
    case ($urandom_range(0, 5))
      0: return NormMin;
      1: return NormMax;
      2: return '0;
      3: return norm_t'($urandom_range(0, 46340) - 23170);
      default: return norm_t'($urandom);
    endcase
  endfunction

  function automatic q16_t pick_speed();
    case ($urandom_range(0, 5))
      0: return QLow;
      1: return QHigh;
      2: return q16_t'($urandom);
      default: return q16_t'($urandom_range(0, 32'h7fffff) - 32'h400000);
    endcase
  endfunction

  function automatic pen_t pick_depth();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return PenMax;
      2: return pen_t'($urandom);
      default: return pen_t'($urandom_range(0, 32'h3ffff));
    endcase
  endfunction

  function automatic dt_t pick_step();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 16'hffff;
      2: return dt_t'($urandom_range(0, 16'h0fff));
      default: return dt_t'($urandom);
    endcase
  endfunction

  function automatic damp_t pick_damp();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 17'h10000;
      2: return 17'h1ffff;
      3: return damp_t'($urandom);
      default: return damp_t'($urandom_range(0, 65536));
    endcase
  endfunction

  // Every field is randomized on every beat, so fields that the operation
  // does not use are exercised as well.
  task automatic send_random_beat();
    op_t op;
    case ($urandom_range(0, 9))
      0: op = OP_RESTART;
      1, 2, 3: op = OP_TICK;
      4, 5, 6: op = OP_BOUNDARY;
      default: op = OP_PARTICLE;
    endcase
    send_beat(op, pick_step(), pick_normal(), pick_normal(), pick_depth(),
              pick_speed(), pick_speed(), pick_damp());
  endtask

  // A phase of random beats, with an occasional full drain in the middle.
  task automatic run_phase(input int beats);
    for (int k = 0; k < beats; k++) begin
      send_random_beat();
      if ($urandom_range(0, 79) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    item_ch.valid         <= 1'b0;
    item_ch.operation     <= OP_RESTART;
    item_ch.step_time     <= '0;
    item_ch.normal_x      <= '0;
    item_ch.normal_y      <= '0;
    item_ch.penetration   <= '0;
    item_ch.other_vel_x   <= '0;
    item_ch.other_vel_y   <= '0;
    item_ch.other_damping <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed beats run on the register values left by reset.
    // A restart with junk in every unused field must return to the origin.
    send_beat(OP_RESTART, dt_t'($urandom), norm_t'($urandom), norm_t'($urandom),
              pen_t'($urandom), q16_t'($urandom), q16_t'($urandom), damp_t'($urandom));
    // Ticks: the longest step, a zero step and a half step.
    send_beat(OP_TICK, 16'hffff, '0, '0, '0, '0, '0, '0);
    send_beat(OP_TICK, 16'h0000, NormMax, NormMin, PenMax, QHigh, QLow, 17'h1ffff);
    send_beat(OP_TICK, 16'h8000, '0, '0, '0, '0, '0, '0);
    // Falling onto a floor whose normal points up: reflect and damp.
    send_beat(OP_BOUNDARY, '0, '0, NormMin, pen_t'(32'h10000), '0, '0, '0);
    // Same floor while moving away from it, with no overlap: nothing changes.
    send_beat(OP_BOUNDARY, '0, '0, NormMin, '0, '0, '0, '0);
    // Normals that are not unit length, with the deepest overlap.
    send_beat(OP_BOUNDARY, '0, NormMax, NormMax, PenMax, '0, '0, '0);
    send_beat(OP_BOUNDARY, '0, NormMin, NormMin, PenMax, '0, '0, '0);
    // Particle contacts: closing on a fast partner, then separating from it.
    send_beat(OP_PARTICLE, '0, NormMax, '0, pen_t'(32'h8000), QHigh, '0, '0);
    send_beat(OP_PARTICLE, '0, NormMin, '0, pen_t'(32'h8000), QHigh, '0, 17'h10000);
    // A zero normal gives no closing speed, which still counts as an impulse of zero.
    send_beat(OP_PARTICLE, '0, '0, '0, PenMax, q16_t'(32'h12345678), QLow, 17'h10000);
    // Extreme partner velocities and a partner damping above one saturate
    // the velocity and the partner share.
    send_beat(OP_PARTICLE, '0, NormMin, NormMin, PenMax, QLow, QLow, 17'h1ffff);
    send_beat(OP_PARTICLE, '0, 16'sd23170, 16'sd23170, '0, q16_t'(32'h10000),
              q16_t'(-32'sh20000), 17'h10000);
    // With a saturated velocity the integration and the reflection saturate.
    send_beat(OP_TICK, 16'hffff, '0, '0, '0, '0, '0, '0);
    send_beat(OP_BOUNDARY, '0, NormMin, NormMax, '0, '0, '0, '0);
    send_beat(OP_PARTICLE, '0, NormMax, NormMin, '0, QHigh, QHigh, '0);
    send_beat(OP_RESTART, '0, '0, '0, '0, '0, '0, '0);
    drain_results();

    // Random phases, each under its own register setting. Gravity and
    // damping take their range limits and values beyond them.
    configure(grav_t'(1310720), 17'h10000, QHigh, QLow);
    run_phase(250);
    configure(grav_t'(-1310720), 17'h00000, q16_t'($urandom), q16_t'($urandom));
    run_phase(250);
    configure(22'sh200000, 17'h1ffff, '0, '0);
    run_phase(250);
    configure(22'sh1fffff, damp_t'($urandom_range(0, 65536)), q16_t'($urandom),
              q16_t'($urandom));
    run_phase(250);

    // The last phase runs with both sides at full speed.
    idle_en <= 1'b0;
    configure(grav_t'($urandom_range(0, 2621440) - 1310720), 17'd52429,
              q16_t'($urandom_range(0, 32'hffffff) - 32'h800000),
              q16_t'($urandom_range(0, 32'hffffff) - 32'h800000));
    run_phase(250);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== particle_collision_integrator.f =====
rtl/pci_pkg.sv
rtl/pci_if.sv
rtl/pci_cfg_regs.sv
rtl/pci_datapath.sv
rtl/pci_ctrl.sv
rtl/particle_collision_integrator.sv
tb/particle_collision_integrator_checker.sv
tb/particle_collision_integrator_tb.sv
